[hdl/rtcm_pkg.sv]
// Package with the shared types, constants and CRC-24Q function of the RTCM3 frame extractor.
`default_nettype none

package rtcm_pkg;

  // Field widths and protocol constants.
  localparam int unsigned FRAME_LEN_W         = 11;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned CRC_W               = 24;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 1029;

  localparam logic [BYTE_W-1:0]      SYNC_BYTE   = 8'hD3;
  localparam logic [FRAME_LEN_W-1:0] HDR_EXTRA   = 11'd6;
  localparam logic [FRAME_LEN_W-1:0] LIMIT_RESET = 11'd1029;
  localparam logic [CRC_W-1:0]       CRC24Q_POLY = 24'h864CFB;

  // Frame tracking phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LEN2 = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  // One result transaction as held in the output register.
  typedef struct packed {
    logic [BYTE_W-1:0]      byte_out;
    logic                   in_frame;
    logic [FRAME_LEN_W-1:0] frame_pos;
    logic                   frame_end;
    logic                   crc_ok;
    logic                   abandon;
    logic [FRAME_LEN_W-1:0] frame_len;
  } result_t;

  // CRC-24Q update over one byte, most significant bit first.
  function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             msb;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      msb = c[CRC_W-1];
      c   = {c[CRC_W-2:0], 1'b0};
      if (msb) begin
        c = c ^ CRC24Q_POLY;
      end
    end
    return c;
  endfunction

  // CRC after the sync byte alone, starting from zero.
  localparam logic [CRC_W-1:0] CRC_AFTER_SYNC = crc24q_byte(24'h000000, SYNC_BYTE);

endpackage

`default_nettype wire

[hdl/rtcm_in_if.sv]
// Valid/ready channel carrying received bytes into the frame extractor.
`default_nettype none

interface rtcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

[hdl/rtcm_out_if.sv]
// Valid/ready channel carrying tagged bytes out of the frame extractor.
`default_nettype none

interface rtcm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        in_frame;
  logic [10:0] frame_pos;
  logic        frame_end;
  logic        crc_ok;
  logic        abandon;
  logic [10:0] frame_len;

  modport source (output valid, output byte_out, output in_frame, output frame_pos,
                  output frame_end, output crc_ok, output abandon, output frame_len,
                  input ready);
  modport sink   (input valid, input byte_out, input in_frame, input frame_pos,
                  input frame_end, input crc_ok, input abandon, input frame_len,
                  output ready);
endinterface

`default_nettype wire

[hdl/rtcm3_frame_extractor.sv]
// RTCM3 frame extractor: tags a received byte stream with frame position, end and CRC status.
//
// Usage: received bytes arrive on byte_in_i, one per transaction. Every accepted byte
// leaves on result_o as exactly one transaction carrying the byte, whether it lies in a
// frame, its offset from the 0xD3 sync byte, the decoded frame length, an end mark with
// the CRC-24Q verdict, and an abandon flag for frames above the size limit.
// The size limit is written through cfg_wr_en_i/cfg_wr_data_i; the user must write it only
// while the block is idle, which the block does not enforce. Values above MAX_FRAME_BYTES act
// as MAX_FRAME_BYTES, values below 6 reject every frame. An accepted byte passes through the
// input register, then the header decode and byte-wise CRC update feeding the result register.
// Throughput is one byte per cycle unless the receiver stalls; the CRC takes a byte at once.
// After reset the block hunts for sync, the limit is 1029 and both registers are empty.
// When the receiver stalls the result register holds its transaction; the input register
// still takes one more byte, after which byte_in_i.ready falls until result_o drains.
`default_nettype none

module rtcm3_frame_extractor
  import rtcm_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [FRAME_LEN_W-1:0] cfg_wr_data_i,
  rtcm_in_if.sink                byte_in_i,
  rtcm_out_if.source             result_o
);

  localparam logic [FRAME_LEN_W-1:0] LimitCap = FRAME_LEN_W'(MAX_FRAME_BYTES);

  // Pipeline control.
  logic                   s1_valid_q, s1_valid_d;
  logic [BYTE_W-1:0]      s1_byte_q;
  logic                   out_valid_q;
  logic                   out_load;
  logic                   s1_adv;
  logic                   in_acc;

  // Configuration and frame state.
  logic [FRAME_LEN_W-1:0] limit_cfg_q;
  phase_e                 phase_q, phase_d;
  logic [BYTE_W-1:0]      first_len_q, first_len_d;
  logic [FRAME_LEN_W-1:0] exp_len_q, exp_len_d;
  logic [FRAME_LEN_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [CRC_W-1:0]       crc_q, crc_d;

  // Shared decode terms.
  logic [FRAME_LEN_W-1:0] size_limit;
  logic [FRAME_LEN_W-1:0] len_dec;
  logic                   oversize;
  logic [FRAME_LEN_W-1:0] cnt_inc;
  logic                   body_done;
  logic [CRC_W-1:0]       crc_upd;
  logic [CRC_W-1:0]       crc_resync;
  logic                   byte_is_sync;
  logic                   first_is_sync;

  result_t                res_q, res_d;

  // Handshake: the input register moves on whenever the result register can load.
  assign out_load        = !out_valid_q || result_o.ready;
  assign s1_adv          = s1_valid_q && out_load;
  assign byte_in_i.ready = !s1_valid_q || out_load;
  assign in_acc          = byte_in_i.valid && byte_in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= byte_in_i.byte_in;
    end
  end

  // Size limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= LIMIT_RESET;
    end else if (cfg_wr_en_i) begin
      limit_cfg_q <= cfg_wr_data_i;
    end
  end

  // Header decode, length check and CRC update for the byte in the input register.
  assign size_limit    = (limit_cfg_q > LimitCap) ? LimitCap : limit_cfg_q;
  assign len_dec       = {1'b0, first_len_q[1:0], s1_byte_q} + HDR_EXTRA;
  assign oversize      = len_dec > size_limit;
  assign cnt_inc       = byte_cnt_q + 11'd1;
  assign body_done     = cnt_inc >= exp_len_q;
  assign crc_upd       = crc24q_byte(crc_q, s1_byte_q);
  assign crc_resync    = crc24q_byte(CRC_AFTER_SYNC, s1_byte_q);
  assign byte_is_sync  = s1_byte_q == SYNC_BYTE;
  assign first_is_sync = first_len_q == SYNC_BYTE;

  // Next frame state.
  always_comb begin
    phase_d     = phase_q;
    first_len_d = first_len_q;
    exp_len_d   = exp_len_q;
    byte_cnt_d  = byte_cnt_q;
    crc_d       = crc_q;
    case (phase_q)
      PH_HUNT: begin
        if (byte_is_sync) begin
          crc_d      = CRC_AFTER_SYNC;
          byte_cnt_d = 11'd1;
          phase_d    = PH_LEN1;
        end
      end
      PH_LEN1: begin
        first_len_d = s1_byte_q;
        crc_d       = crc_upd;
        byte_cnt_d  = 11'd2;
        phase_d     = PH_LEN2;
      end
      PH_LEN2: begin
        if (oversize) begin
          if (first_is_sync) begin
            // The first length byte becomes a new sync byte.
            crc_d       = crc_resync;
            first_len_d = s1_byte_q;
            byte_cnt_d  = 11'd2;
            phase_d     = PH_LEN2;
          end else if (byte_is_sync) begin
            crc_d      = CRC_AFTER_SYNC;
            byte_cnt_d = 11'd1;
            phase_d    = PH_LEN1;
          end else begin
            phase_d    = PH_HUNT;
            byte_cnt_d = '0;
            crc_d      = '0;
          end
        end else begin
          crc_d      = crc_upd;
          exp_len_d  = len_dec;
          byte_cnt_d = 11'd3;
          phase_d    = PH_BODY;
        end
      end
      PH_BODY: begin
        crc_d      = crc_upd;
        byte_cnt_d = cnt_inc;
        if (body_done) begin
          phase_d    = PH_HUNT;
          byte_cnt_d = '0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // Result fields for the byte in the input register.
  always_comb begin
    res_d           = '0;
    res_d.byte_out  = s1_byte_q;
    case (phase_q)
      PH_HUNT: begin
        res_d.in_frame = byte_is_sync;
      end
      PH_LEN1: begin
        res_d.in_frame  = 1'b1;
        res_d.frame_pos = 11'd1;
      end
      PH_LEN2: begin
        if (oversize) begin
          res_d.abandon = 1'b1;
          if (first_is_sync) begin
            res_d.in_frame  = 1'b1;
            res_d.frame_pos = 11'd1;
          end else begin
            res_d.in_frame = byte_is_sync;
          end
        end else begin
          res_d.in_frame  = 1'b1;
          res_d.frame_pos = 11'd2;
          res_d.frame_len = len_dec;
        end
      end
      PH_BODY: begin
        res_d.in_frame  = 1'b1;
        res_d.frame_pos = byte_cnt_q;
        res_d.frame_len = exp_len_q;
        res_d.frame_end = body_done;
        res_d.crc_ok    = body_done && (crc_upd == '0);
      end
      default: begin
        res_d.in_frame = 1'b0;
      end
    endcase
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      first_len_q <= '0;
      exp_len_q   <= '0;
      byte_cnt_q  <= '0;
      crc_q       <= '0;
    end else if (s1_adv) begin
      phase_q     <= phase_d;
      first_len_q <= first_len_d;
      exp_len_q   <= exp_len_d;
      byte_cnt_q  <= byte_cnt_d;
      crc_q       <= crc_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.byte_out  = res_q.byte_out;
  assign result_o.in_frame  = res_q.in_frame;
  assign result_o.frame_pos = res_q.frame_pos;
  assign result_o.frame_end = res_q.frame_end;
  assign result_o.crc_ok    = res_q.crc_ok;
  assign result_o.abandon   = res_q.abandon;
  assign result_o.frame_len = res_q.frame_len;

  // A frame body never holds a count at or past its expected length.
  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (byte_cnt_q < exp_len_q))
    else $error("byte count reached expected length inside a frame body");

  // An end mark always closes a byte that lies in a frame of known length.
  a_end_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_end) |-> (res_q.in_frame && res_q.frame_len != '0))
    else $error("frame end outside a frame");

  // CRC status is only reported on the last byte of a frame.
  a_crc_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.crc_ok) |-> res_q.frame_end)
    else $error("crc_ok without frame end");

  // An abandoned frame carries no length and no end mark.
  a_abandon_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.abandon) |-> (res_q.frame_len == '0 && !res_q.frame_end))
    else $error("abandon with frame length or end mark");

  // A decoded length never exceeds the active size limit when the frame is entered.
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && phase_q == PH_LEN2 && phase_d == PH_BODY) |-> (len_dec <= size_limit))
    else $error("frame accepted above size limit");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the RTCM3 frame extractor: frames, noise, size limits and CRC.
`default_nettype none

module testbench;
  import rtcm_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_wr_en;
  logic [FRAME_LEN_W-1:0] cfg_wr_data;

  rtcm_in_if  in_if ();
  rtcm_out_if out_if ();

  rtcm3_frame_extractor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .byte_in_i     (in_if),
    .result_o      (out_if)
  );

  // Frame tracker state, mirrored from the block after reset.
  phase_e                 frame_phase = PH_HUNT;
  logic [BYTE_W-1:0]      len_hi      = '0;
  logic [FRAME_LEN_W-1:0] frame_size  = '0;
  logic [FRAME_LEN_W-1:0] byte_idx    = '0;
  logic [CRC_W-1:0]       crc_acc     = '0;
  logic [FRAME_LEN_W-1:0] limit_reg   = LIMIT_RESET;

  result_t pending_tags[$];
  int      tag_errors     = 0;
  int      items_sent     = 0;
  int      idle_pct       = 10;
  int      stall_pct      = 10;
  int      stalled_cycles = 0;

  // Clock and a single reset at the start of the run.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // CRC-24Q, one input bit at a time, most significant bit first.
  function automatic logic [CRC_W-1:0] crc24q_step(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ b[i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ 24'h864CFB;
      end
    end
    return c;
  endfunction

  // Advances the frame tracker by one byte and returns the tags the block should attach.
  function automatic result_t tag_next_byte(input logic [BYTE_W-1:0] b);
    result_t                t;
    logic [FRAME_LEN_W-1:0] size;
    logic [FRAME_LEN_W-1:0] cap;
    t          = '0;
    t.byte_out = b;
    cap = (limit_reg > MAX_FRAME_BYTES_DEF) ? FRAME_LEN_W'(MAX_FRAME_BYTES_DEF) : limit_reg;
    case (frame_phase)
      PH_HUNT: begin
        if (b == SYNC_BYTE) begin
          crc_acc     = crc24q_step('0, b);
          byte_idx    = 1;
          frame_phase = PH_LEN1;
          t.in_frame  = 1'b1;
        end
      end
      PH_LEN1: begin
        len_hi      = b;
        crc_acc     = crc24q_step(crc_acc, b);
        byte_idx    = 2;
        frame_phase = PH_LEN2;
        t.in_frame  = 1'b1;
        t.frame_pos = 1;
      end
      PH_LEN2: begin
        size = {1'b0, len_hi[1:0], b} + HDR_EXTRA;
        if (size > cap) begin
          // Too long: look again at the two length bytes for a fresh sync.
          t.abandon = 1'b1;
          if (len_hi == SYNC_BYTE) begin
            crc_acc     = crc24q_step(crc24q_step('0, SYNC_BYTE), b);
            len_hi      = b;
            byte_idx    = 2;
            frame_phase = PH_LEN2;
            t.in_frame  = 1'b1;
            t.frame_pos = 1;
          end else if (b == SYNC_BYTE) begin
            crc_acc     = crc24q_step('0, b);
            byte_idx    = 1;
            frame_phase = PH_LEN1;
            t.in_frame  = 1'b1;
          end else begin
            frame_phase = PH_HUNT;
            byte_idx    = 0;
            crc_acc     = '0;
          end
        end else begin
          crc_acc     = crc24q_step(crc_acc, b);
          frame_size  = size;
          byte_idx    = 3;
          frame_phase = PH_BODY;
          t.in_frame  = 1'b1;
          t.frame_pos = 2;
          t.frame_len = size;
        end
      end
      default: begin
        crc_acc     = crc24q_step(crc_acc, b);
        t.in_frame  = 1'b1;
        t.frame_pos = byte_idx;
        t.frame_len = frame_size;
        byte_idx    = byte_idx + 1'b1;
        if (byte_idx >= frame_size) begin
          t.frame_end = 1'b1;
          t.crc_ok    = (crc_acc == '0);
          frame_phase = PH_HUNT;
          byte_idx    = 0;
        end
      end
    endcase
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    tag_errors++;
    if (tag_errors <= 40) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  // Result side: compare each result transaction, then predict the byte taken at this edge.
  always @(posedge clk_i) begin : check_tags
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.byte_out, out_if.in_frame, out_if.frame_pos, out_if.frame_end,
               out_if.crc_ok, out_if.abandon, out_if.frame_len};
        if (pending_tags.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, byte %h", got.byte_out));
        end else begin
          want = pending_tags.pop_front();
          if (got.byte_out !== want.byte_out)
            report_mismatch($sformatf("byte_out %h, want %h", got.byte_out, want.byte_out));
          if (got.in_frame !== want.in_frame)
            report_mismatch($sformatf("in_frame %b, want %b", got.in_frame, want.in_frame));
          if (got.frame_pos !== want.frame_pos)
            report_mismatch($sformatf("frame_pos %0d, want %0d", got.frame_pos,
                                      want.frame_pos));
          if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, want %b", got.frame_end,
                                      want.frame_end));
          if (got.crc_ok !== want.crc_ok)
            report_mismatch($sformatf("crc_ok %b, want %b", got.crc_ok, want.crc_ok));
          if (got.abandon !== want.abandon)
            report_mismatch($sformatf("abandon %b, want %b", got.abandon, want.abandon));
          if (got.frame_len !== want.frame_len)
            report_mismatch($sformatf("frame_len %0d, want %0d", got.frame_len,
                                      want.frame_len));
        end
      end
      if (in_if.valid && in_if.ready) begin
        pending_tags.push_back(tag_next_byte(in_if.byte_in));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= 2000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls at random.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one byte, with random gaps before it, and returns once it is taken.
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // Sends a frame with the given payload size; a corrupt frame has one byte damaged after
  // the header, and a non-zero cut sends only that many leading bytes.
  task automatic send_frame(input int payload_len, input bit corrupt, input int cut);
    logic [BYTE_W-1:0] fr[$];
    logic [CRC_W-1:0]  c;
    logic [9:0]        len;
    logic [BYTE_W-1:0] hi;
    int                idx;
    len = 10'(payload_len);
    hi  = 8'($urandom);
    hi[1:0] = len[9:8];
    fr.push_back(SYNC_BYTE);
    fr.push_back(hi);
    fr.push_back(len[7:0]);
    repeat (payload_len) fr.push_back(8'($urandom));
    c = '0;
    foreach (fr[i]) c = crc24q_step(c, fr[i]);
    fr.push_back(c[23:16]);
    fr.push_back(c[15:8]);
    fr.push_back(c[7:0]);
    if (corrupt) begin
      idx = $urandom_range(3, fr.size() - 1);
      fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
    end
    foreach (fr[i]) begin
      if (cut == 0 || i < cut) begin
        push_byte(fr[i]);
      end
    end
  endtask

  // Writes the size limit once every pending result has come back.
  task automatic set_limit(input logic [FRAME_LEN_W-1:0] lim);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(negedge clk_i);
    cfg_wr_en   <= 1'b0;
    limit_reg = lim;
  endtask

  // Non-sync bytes while hunting are echoed untagged.
  task automatic test_hunt_bytes();
    push_byte(8'h00);
    push_byte(8'hFF);
  endtask

  // Shortest frames, one with a good CRC and one with a bad one.
  task automatic test_short_frames();
    send_frame(0, 1'b0, 0);
    send_frame(0, 1'b1, 0);
  endtask

  // Oversize headers under a limit of 64 bytes.
  task automatic test_oversize_headers();
    set_limit(11'd64);
    // Neither length byte is a sync: hunting resumes.
    push_byte(SYNC_BYTE);
    push_byte(8'h01);
    push_byte(8'h00);
    // The second length byte is a sync: a frame starts there.
    push_byte(SYNC_BYTE);
    push_byte(8'h00);
    push_byte(SYNC_BYTE);
    push_byte(8'h03);
    push_byte(8'hFF);
    // The first length byte is a sync: the current byte becomes position 1.
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(8'h02);
    push_byte(8'h00);
  endtask

  // Random mix of good, damaged and cut frames and noise bytes.
  task automatic run_stream(input int n_items);
    int stop;
    int pick;
    int len;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(19) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
      if (pick < 65) begin
        send_frame(len, $urandom_range(99) < 15, 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
        end
      end else begin
        send_frame(len, 1'b0, $urandom_range(1, 8));
      end
    end
  endtask

  // One limit setting: with at_bounds, frames right at the limit and one byte over it, then random traffic.
  task automatic test_limit_phase(input logic [FRAME_LEN_W-1:0] lim, input bit at_bounds,
                                  input int n_items);
    int cap;
    set_limit(lim);
    cap = (lim > MAX_FRAME_BYTES_DEF) ? MAX_FRAME_BYTES_DEF : lim;
    if (at_bounds) begin
      if (cap >= 6) begin
        send_frame(cap - 6, 1'b0, 0);
      end
      if (cap < MAX_FRAME_BYTES_DEF) begin
        send_frame((cap >= 6) ? cap - 5 : 0, 1'b0, 0);
      end
    end
    run_stream(n_items);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_if.valid   = 1'b0;
    in_if.byte_in = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_hunt_bytes();
    test_short_frames();
    test_oversize_headers();

    test_limit_phase(LIMIT_RESET, 1'b0, 250);
    // A stretch with no gaps on either side.
    idle_pct  = 0;
    stall_pct = 0;
    test_limit_phase(11'd64, 1'b1, 250);
    idle_pct  = 10;
    stall_pct = 10;
    test_limit_phase(11'd6, 1'b1, 200);
    test_limit_phase(11'd2047, 1'b0, 150);
    test_limit_phase(11'd0, 1'b1, 120);

    // Drain the remaining results, then allow for anything extra the block might send.
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tag_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/rtcm_pkg.sv
hdl/rtcm_in_if.sv
hdl/rtcm_out_if.sv
hdl/rtcm3_frame_extractor.sv
bench/testbench.sv
